@@ rtl/clr_pkg.sv @@
// Shared constants, types and helpers of the clipped line rasteriser.
package clr_pkg;

    localparam int COORD_BITS  = 16;
    localparam int SCREEN_BITS = 12;

    localparam int CW   = COORD_BITS;
    localparam int SW   = SCREEN_BITS;
    localparam int MAXW = (CW > SW + 1) ? CW : SW + 1;
    // signed width of coordinates, deltas and edge distances
    localparam int EW   = MAXW + 2;
    // cross products: edge numerator times a denominator
    localparam int PW   = EW + CW;
    localparam int DCW  = $clog2(CW);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        KIND_IDLE   = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_PIXEL  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_RIGHT  = 2'd1,
        REG_CLIP_BOTTOM = 2'd2,
        REG_CLIP_TOP    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] left;
        logic [12:0] right;
        logic [11:0] bottom;
        logic [12:0] top;
    } clip_cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_EDGE,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_MUL4,
        OP_DECIDE,
        OP_PMUL,
        OP_DLOAD,
        OP_DSTEP,
        OP_PFIN,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        kind_t  kind;
    } dp_cmd_t;

    typedef struct packed {
        logic reject;
        logic last_edge;
        logic last_point;
        logic div_last;
        logic busy;
    } dp_stat_t;

    function automatic logic signed [EW-1:0] to_coord(input logic [15:0] v);
        logic signed [CW-1:0] c;
        c = v[CW-1:0];
        return EW'(c);
    endfunction

endpackage

@@ rtl/clr_if.sv @@
// Item channel interfaces: segment/step requests in, results out.
interface clr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [31:0] line_color;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

interface clr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_color;
    logic        last;

    modport source (output valid, kind, pixel_x, pixel_y, pixel_color, last,
                    input ready);
    modport sink   (input valid, kind, pixel_x, pixel_y, pixel_color, last,
                    output ready);
endinterface

@@ rtl/clr_cfg.sv @@
// APB register file holding the scissor rectangle.
module clr_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output clr_pkg::clip_cfg_t   cfg
);
    import clr_pkg::*;

    clip_cfg_t cfg_reg;
    reg_idx_t  idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left   <= 12'd0;
            cfg_reg.right  <= 13'd4096;
            cfg_reg.bottom <= 12'd0;
            cfg_reg.top    <= 13'd4096;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_CLIP_LEFT:   cfg_reg.left   <= pwdata[11:0];
                REG_CLIP_RIGHT:  cfg_reg.right  <= pwdata[12:0];
                REG_CLIP_BOTTOM: cfg_reg.bottom <= pwdata[11:0];
                REG_CLIP_TOP:    cfg_reg.top    <= pwdata[12:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CLIP_LEFT:   prdata = 32'(cfg_reg.left);
            REG_CLIP_RIGHT:  prdata = 32'(cfg_reg.right);
            REG_CLIP_BOTTOM: prdata = 32'(cfg_reg.bottom);
            REG_CLIP_TOP:    prdata = 32'(cfg_reg.top);
        endcase
    end

endmodule

@@ rtl/clr_dp.sv @@
// Datapath: clip fractions, shared multiplier, serial divider, line walker, result register.
module clr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  clr_pkg::clip_cfg_t  cfg,
    input  clr_pkg::dp_cmd_t    cmd,
    output clr_pkg::dp_stat_t   stat,
    input  logic [15:0]         start_x,
    input  logic [15:0]         start_y,
    input  logic [15:0]         end_x,
    input  logic [15:0]         end_y,
    input  logic [31:0]         line_color,
    output logic [1:0]          kind,
    output logic [11:0]         pixel_x,
    output logic [11:0]         pixel_y,
    output logic [31:0]         pixel_color,
    output logic                last
);
    import clr_pkg::*;

    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_TOP    = 2'd3;
    localparam logic [1:0] PT_LAST     = 2'd3;
    localparam logic signed [EW-1:0] LIM = EW'(1 << SW);

    // segment and rectangle
    logic signed [EW-1:0] x0_reg, y0_reg, dx_reg, dy_reg;
    logic signed [EW-1:0] l_reg, b_reg, r_reg, t_reg;
    logic [31:0]          color_in_reg;

    // current edge
    logic                 pzero_reg, pneg_reg, qneg_reg, rn_neg_reg;
    logic [EW-1:0]        rn_mag_reg;
    logic [CW-1:0]        rd_reg;
    logic [CW-1:0]        t0n_reg, t0d_reg, t1n_reg, t1d_reg;
    logic [PW-1:0]        p_reg, a_reg;
    logic                 gt1_reg, lt1_reg;

    // clip point division
    logic                 dneg_reg;
    logic [CW-1:0]        dvs_reg, rem_reg, dq_reg;
    logic [SW-1:0]        ax_reg, ay_reg, bx_reg, by_reg;

    // walker
    logic                 busy_reg, x_major_reg, up_reg;
    logic [SW-1:0]        from_major_reg, from_minor_reg, to_major_reg, to_minor_reg;
    logic [SW-1:0]        walk_reg, dmaj_reg, dm_reg, acc_q_reg, acc_rem_reg;
    logic [31:0]          held_color_reg;

    // control counters
    logic [1:0]           edge_reg, pt_reg;
    logic [DCW-1:0]       div_cnt_reg;

    // result register
    logic [1:0]           kind_reg;
    logic [11:0]          px_reg, py_reg;
    logic [31:0]          pc_reg;
    logic                 last_reg;

    logic signed [EW-1:0] sx0, sy0, sx1, sy1, right_e, top_e;
    logic signed [EW-1:0] p_sel, q_sel, rn, p_abs, d_sel, d_abs;
    logic [EW-1:0]        mul_a;
    logic [CW-1:0]        mul_b, tn_sel, td_sel;
    logic                 gt0, lt0, reject;
    logic [CW:0]          rem_sh;
    logic                 div_ge;
    logic [CW:0]          rem_sub;
    logic signed [EW-1:0] c0;
    logic [MAXW-1:0]      qw;
    logic [SW-1:0]        c0s, qs, pt_res;
    logic [SW-1:0]        adx, ady, ma, na, mb, nb, dmin_u, dmin_d;
    logic                 xm, swap;
    logic [SW-1:0]        s_from_maj, s_from_min, s_to_maj, s_to_min;
    logic [SW-1:0]        minor;
    logic                 fin;
    logic [SW:0]          acc_sum, acc_sub;
    logic                 acc_wrap;

    assign sx0     = to_coord(start_x);
    assign sy0     = to_coord(start_y);
    assign sx1     = to_coord(end_x);
    assign sy1     = to_coord(end_y);
    assign right_e = EW'(cfg.right);
    assign top_e   = EW'(cfg.top);

    // edge p and q
    always_comb
    begin
        unique case (edge_reg)
            EDGE_LEFT:
            begin
                p_sel = -dx_reg;
                q_sel = x0_reg - l_reg;
            end
            EDGE_RIGHT:
            begin
                p_sel = dx_reg;
                q_sel = r_reg - x0_reg;
            end
            EDGE_BOTTOM:
            begin
                p_sel = -dy_reg;
                q_sel = y0_reg - b_reg;
            end
            EDGE_TOP:
            begin
                p_sel = dy_reg;
                q_sel = t_reg - y0_reg;
            end
        endcase
        rn    = (p_sel < 0) ? -q_sel : q_sel;
        p_abs = (p_sel < 0) ? -p_sel : p_sel;
    end

    // clip point operands
    assign d_sel  = pt_reg[0] ? dy_reg : dx_reg;
    assign d_abs  = (d_sel < 0) ? -d_sel : d_sel;
    assign tn_sel = pt_reg[1] ? t1n_reg : t0n_reg;
    assign td_sel = pt_reg[1] ? t1d_reg : t0d_reg;

    always_comb
    begin
        unique case (cmd.op)
            OP_MUL1:
            begin
                mul_a = rn_mag_reg;
                mul_b = t1d_reg;
            end
            OP_MUL2:
            begin
                mul_a = EW'(t1n_reg);
                mul_b = rd_reg;
            end
            OP_MUL3:
            begin
                mul_a = rn_mag_reg;
                mul_b = t0d_reg;
            end
            OP_MUL4:
            begin
                mul_a = EW'(t0n_reg);
                mul_b = rd_reg;
            end
            default:
            begin
                mul_a = EW'(d_abs[CW-1:0]);
                mul_b = tn_sel;
            end
        endcase
    end

    // a negative numerator compares below any non-negative fraction
    assign gt0    = !rn_neg_reg && (a_reg > p_reg);
    assign lt0    = rn_neg_reg || (a_reg < p_reg);
    assign reject = pzero_reg ? qneg_reg : (pneg_reg ? gt1_reg : lt0);

    // restoring divider step
    assign rem_sh  = {rem_reg, dq_reg[CW-1]};
    assign div_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // floor of the clipped point: subtract the ceiling when the delta is negative
    assign c0     = pt_reg[0] ? y0_reg : x0_reg;
    assign c0s    = c0[SW-1:0];
    assign qw     = MAXW'(dq_reg);
    assign qs     = qw[SW-1:0];
    assign pt_res = dneg_reg ? (c0s - qs - SW'(rem_reg != '0)) : (c0s + qs);

    // walk setup
    always_comb
    begin
        adx    = (ax_reg > bx_reg) ? ax_reg - bx_reg : bx_reg - ax_reg;
        ady    = (ay_reg > by_reg) ? ay_reg - by_reg : by_reg - ay_reg;
        xm     = adx > ady;
        ma     = xm ? ax_reg : ay_reg;
        na     = xm ? ay_reg : ax_reg;
        mb     = xm ? bx_reg : by_reg;
        nb     = xm ? by_reg : bx_reg;
        swap   = ma > mb;
        s_from_maj = swap ? mb : ma;
        s_from_min = swap ? nb : na;
        s_to_maj   = swap ? ma : mb;
        s_to_min   = swap ? na : nb;
        dmin_u = s_to_min - s_from_min;
        dmin_d = s_from_min - s_to_min;
    end

    // incremental floor(dm * k / dmaj): dm never exceeds dmaj, so one subtract a pixel
    assign minor    = up_reg ? (from_minor_reg + acc_q_reg)
                             : (from_minor_reg - acc_q_reg - SW'(acc_rem_reg != '0));
    assign fin      = walk_reg >= to_major_reg;
    assign acc_sum  = {1'b0, acc_rem_reg} + {1'b0, dm_reg};
    assign acc_wrap = acc_sum >= {1'b0, dmaj_reg};
    assign acc_sub  = acc_sum - {1'b0, dmaj_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            edge_reg    <= '0;
            pt_reg      <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    edge_reg <= EDGE_LEFT;
                    pt_reg   <= '0;
                end
                OP_DECIDE: edge_reg <= edge_reg + 2'd1;
                OP_DLOAD:  div_cnt_reg <= '0;
                OP_DSTEP:  div_cnt_reg <= div_cnt_reg + DCW'(1);
                OP_PFIN:   pt_reg <= pt_reg + 2'd1;
                OP_EMIT:
                begin
                    unique case (cmd.kind)
                        KIND_REJECT: busy_reg <= 1'b0;
                        KIND_ACCEPT: busy_reg <= 1'b1;
                        KIND_PIXEL:  busy_reg <= !fin;
                        KIND_IDLE:   busy_reg <= busy_reg;
                    endcase
                end
                default: busy_reg <= busy_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                x0_reg       <= sx0;
                y0_reg       <= sy0;
                dx_reg       <= sx1 - sx0;
                dy_reg       <= sy1 - sy0;
                l_reg        <= EW'(cfg.left);
                b_reg        <= EW'(cfg.bottom);
                r_reg        <= ((right_e > LIM) ? LIM : right_e) - EW'(1);
                t_reg        <= ((top_e > LIM) ? LIM : top_e) - EW'(1);
                color_in_reg <= line_color;
                t0n_reg      <= '0;
                t0d_reg      <= CW'(1);
                t1n_reg      <= CW'(1);
                t1d_reg      <= CW'(1);
            end
            OP_EDGE:
            begin
                pzero_reg  <= p_sel == '0;
                pneg_reg   <= p_sel < 0;
                qneg_reg   <= q_sel < 0;
                rn_neg_reg <= rn < 0;
                rn_mag_reg <= (rn < 0) ? '0 : rn;
                rd_reg     <= p_abs[CW-1:0];
            end
            OP_MUL1: p_reg <= mul_a * mul_b;
            OP_MUL2:
            begin
                a_reg <= p_reg;
                p_reg <= mul_a * mul_b;
            end
            OP_MUL3:
            begin
                gt1_reg <= !rn_neg_reg && (a_reg > p_reg);
                lt1_reg <= rn_neg_reg || (a_reg < p_reg);
                p_reg   <= mul_a * mul_b;
            end
            OP_MUL4:
            begin
                a_reg <= p_reg;
                p_reg <= mul_a * mul_b;
            end
            OP_DECIDE:
            begin
                if (!reject && !pzero_reg)
                begin
                    if (pneg_reg && gt0)
                    begin
                        t0n_reg <= rn_mag_reg[CW-1:0];
                        t0d_reg <= rd_reg;
                    end
                    if (!pneg_reg && lt1_reg)
                    begin
                        t1n_reg <= rn_mag_reg[CW-1:0];
                        t1d_reg <= rd_reg;
                    end
                end
            end
            OP_PMUL:
            begin
                p_reg    <= mul_a * mul_b;
                dneg_reg <= d_sel < 0;
                dvs_reg  <= td_sel;
            end
            OP_DLOAD:
            begin
                rem_reg <= p_reg[2*CW-1:CW];
                dq_reg  <= p_reg[CW-1:0];
            end
            OP_DSTEP:
            begin
                rem_reg <= div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                dq_reg  <= {dq_reg[CW-2:0], div_ge};
            end
            OP_PFIN:
            begin
                unique case (pt_reg)
                    2'd0: ax_reg <= pt_res;
                    2'd1: ay_reg <= pt_res;
                    2'd2: bx_reg <= pt_res;
                    2'd3: by_reg <= pt_res;
                endcase
            end
            OP_EMIT:
            begin
                kind_reg <= cmd.kind;
                px_reg   <= '0;
                py_reg   <= '0;
                pc_reg   <= '0;
                last_reg <= 1'b0;
                unique case (cmd.kind)
                    KIND_ACCEPT:
                    begin
                        x_major_reg    <= xm;
                        from_major_reg <= s_from_maj;
                        from_minor_reg <= s_from_min;
                        to_major_reg   <= s_to_maj;
                        to_minor_reg   <= s_to_min;
                        walk_reg       <= s_from_maj;
                        dmaj_reg       <= s_to_maj - s_from_maj;
                        up_reg         <= s_to_min >= s_from_min;
                        dm_reg         <= (s_to_min >= s_from_min) ? dmin_u : dmin_d;
                        acc_q_reg      <= '0;
                        acc_rem_reg    <= '0;
                        held_color_reg <= color_in_reg;
                    end
                    KIND_PIXEL:
                    begin
                        px_reg   <= 12'(x_major_reg ? walk_reg : minor);
                        py_reg   <= 12'(x_major_reg ? minor : walk_reg);
                        pc_reg   <= held_color_reg;
                        last_reg <= fin;
                        if (!fin)
                        begin
                            walk_reg    <= walk_reg + SW'(1);
                            acc_q_reg   <= acc_q_reg + SW'(acc_wrap);
                            acc_rem_reg <= acc_wrap ? acc_sub[SW-1:0] : acc_sum[SW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign stat.reject     = reject;
    assign stat.last_edge  = edge_reg == EDGE_TOP;
    assign stat.last_point = pt_reg == PT_LAST;
    assign stat.div_last   = div_cnt_reg == DCW'(CW - 1);
    assign stat.busy       = busy_reg;

    assign kind        = kind_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;
    assign last        = last_reg;

endmodule

@@ rtl/clr_ctrl.sv @@
// Controller: sequences clipping, point divisions and result hand-off.
module clr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_cmd,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    output clr_pkg::dp_cmd_t   dp_cmd,
    input  clr_pkg::dp_stat_t  dp_stat
);
    import clr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_DECIDE,
        S_PMUL,
        S_DLOAD,
        S_DSTEP,
        S_PFIN,
        S_EMIT
    } state_t;

    state_t state_reg;
    kind_t  kind_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        dp_cmd.kind = kind_reg;
        unique case (state_reg)
            S_IDLE:   dp_cmd.op = (in_valid && in_cmd == CMD_START) ? OP_LOAD : OP_NONE;
            S_EDGE:   dp_cmd.op = OP_EDGE;
            S_MUL1:   dp_cmd.op = OP_MUL1;
            S_MUL2:   dp_cmd.op = OP_MUL2;
            S_MUL3:   dp_cmd.op = OP_MUL3;
            S_MUL4:   dp_cmd.op = OP_MUL4;
            S_DECIDE: dp_cmd.op = OP_DECIDE;
            S_PMUL:   dp_cmd.op = OP_PMUL;
            S_DLOAD:  dp_cmd.op = OP_DLOAD;
            S_DSTEP:  dp_cmd.op = OP_DSTEP;
            S_PFIN:   dp_cmd.op = OP_PFIN;
            S_EMIT:   dp_cmd.op = out_free ? OP_EMIT : OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_EMIT the register is either refilled or still held
            if (out_ready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_cmd == CMD_START)
                            state_reg <= S_EDGE;
                        else
                        begin
                            kind_reg  <= dp_stat.busy ? KIND_PIXEL : KIND_IDLE;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EDGE: state_reg <= S_MUL1;
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_MUL3;
                S_MUL3: state_reg <= S_MUL4;
                S_MUL4: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (dp_stat.reject)
                    begin
                        kind_reg  <= KIND_REJECT;
                        state_reg <= S_EMIT;
                    end
                    else if (dp_stat.last_edge)
                        state_reg <= S_PMUL;
                    else
                        state_reg <= S_EDGE;
                end
                S_PMUL:  state_reg <= S_DLOAD;
                S_DLOAD: state_reg <= S_DSTEP;
                S_DSTEP:
                begin
                    if (dp_stat.div_last)
                        state_reg <= S_PFIN;
                end
                S_PFIN:
                begin
                    if (dp_stat.last_point)
                    begin
                        kind_reg  <= KIND_ACCEPT;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_PMUL;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/clipped_line_rasterizer_top.sv @@
// Top level of the clipped line rasteriser.
// Usage:
//   item_in carries one item per valid/ready handshake. cmd = start loads two
//   endpoints and a colour; the segment is clipped against the scissor rectangle
//   and one result (rejected or accepted) follows. cmd = step then returns one
//   pixel along the major axis per item, the final one flagged by last; a step
//   with no segment in progress returns an idle result.
//   item_out returns exactly one result per input item, in order.
// Sequencing:
//   A step goes from the accepting cycle to the emit state, which loads the output
//   register from the incremental minor-axis walker once that register is free;
//   the result is registered there. A start loads in the accepting cycle, then runs
//   the left, right, bottom and top edges through the shared multiplier (edge,
//   four multiply and decide states each), four clipped points (multiply, divider
//   load, 16 steps of the one-bit-per-cycle restoring divider, finish) and the
//   emit state that loads the output; a rejected segment ends as soon as its edge
//   fails. One item is worked on at a time.
// Reset and stalls:
//   rst_n clears the scissor to the full screen and drops any walk in progress.
//   While a result waits for item_out.ready, the next item may be accepted and
//   worked on; its own result waits until the output register frees.
//   The scissor registers sit on the APB port at byte addresses 0, 4, 8 and 12.
module clipped_line_rasterizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    clr_in_if.sink      item_in,
    clr_out_if.source   item_out
);
    import clr_pkg::*;

    clip_cfg_t cfg;
    dp_cmd_t   dp_cmd;
    dp_stat_t  dp_stat;

    clr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_cmd    (item_in.cmd),
        .in_ready  (item_in.ready),
        .out_ready (item_out.ready),
        .out_valid (item_out.valid),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    clr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .start_x     (item_in.start_x),
        .start_y     (item_in.start_y),
        .end_x       (item_in.end_x),
        .end_y       (item_in.end_y),
        .line_color  (item_in.line_color),
        .kind        (item_out.kind),
        .pixel_x     (item_out.pixel_x),
        .pixel_y     (item_out.pixel_y),
        .pixel_color (item_out.pixel_color),
        .last        (item_out.last)
    );

`ifndef SYNTHESIS
    // a result is only written into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.op == OP_EMIT |-> (!item_out.valid || item_out.ready))
        else $error("result written over a pending item");

    // an accepted start item is latched in the same cycle
    a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready && item_in.cmd == CMD_START)
        |-> dp_cmd.op == OP_LOAD)
        else $error("start item not loaded into datapath");

    // pixels are only produced during a walk
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == OP_EMIT && dp_cmd.kind == KIND_PIXEL) |-> dp_stat.busy)
        else $error("pixel emitted with no segment in progress");

    // emitting a result raises valid on the next edge
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.op == OP_EMIT |=> item_out.valid)
        else $error("emitted result not presented");
`endif

endmodule
